### rtl/sac_pkg.sv
// Shared types, constants and defaults for the set-associative write-through cache.
`timescale 1ns / 1ps

package sac_pkg;

  localparam int DEF_SETS       = 16;
  localparam int DEF_WAYS       = 4;
  localparam int DEF_LINE_BYTES = 16;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_REQ   = 3'd1;
  localparam logic [2:0] KIND_MEMW  = 3'd2;
  localparam logic [2:0] KIND_MISAL = 3'd3;
  localparam logic [2:0] KIND_BUSY  = 3'd4;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_REFILL = 2'd2;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_REFILL,
    OP_BAD,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] address;
    logic [2:0]  size;
    logic [31:0] wdata;
    logic [31:0] rdata;
  } q_item_t;

endpackage

### rtl/sac_front.sv
// Front end: classifies incoming items, drops those of mode three and holds the rest in a two-entry queue.
`timescale 1ns / 1ps

module sac_front import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic [2:0]  size_bytes,
  input  logic [31:0] write_data,
  input  logic [31:0] refill_data,
  output logic        q_valid,
  output q_item_t     q_item,
  input  logic        q_pop
);

  q_item_t    ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  q_item_t    cls;
  logic       bad;
  logic       push;

  always_comb begin
    bad = 1'b1;
    if (size_bytes == 3'd1) begin
      bad = 1'b0;
    end else if (size_bytes == 3'd2) begin
      bad = address[0];
    end else if (size_bytes == 3'd4) begin
      bad = (address[1:0] != 2'b00);
    end
    cls.address = address;
    cls.size    = size_bytes;
    cls.wdata   = write_data;
    cls.rdata   = refill_data;
    priority if (mode == MODE_REFILL) begin
      cls.op = OP_REFILL;
    end else if (mode == MODE_READ || mode == MODE_WRITE) begin
      cls.op = bad ? OP_BAD : ((mode == MODE_READ) ? OP_READ : OP_WRITE);
    end else begin
      cls.op = OP_DROP;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall && (cls.op != OP_DROP);
  assign q_valid  = (count != 2'd0);
  assign q_item   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        ent[wr_ptr] <= cls;
        wr_ptr      <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### rtl/sac_back.sv
// Back end: tag and data memories, hit check, miss refill and result register.
`timescale 1ns / 1ps

module sac_back import sac_pkg::*; #(
  parameter int SETS       = DEF_SETS,
  parameter int WAYS       = DEF_WAYS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] read_data,
  output logic [31:0] mem_address,
  output logic [31:0] mem_data,
  output logic [3:0]  mem_byte_mask,
  output logic        hit,
  output logic [31:0] hit_count,
  output logic [31:0] access_count,
  output logic [31:0] time_total
);

  localparam int WPL      = LINE_BYTES / 4;
  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int LOG_SETS = $clog2(SETS);
  localparam int LOG_WPL  = $clog2(WPL);
  localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
  localparam int WI_W     = (LOG_WPL > 0) ? LOG_WPL : 1;
  localparam int WAY_W    = ($clog2(WAYS) > 0) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = 32 - OFF_W - LOG_SETS;
  localparam int DADDR_W  = (LOG_SETS + LOG_WPL > 0) ? (LOG_SETS + LOG_WPL) : 1;
  localparam int DEPTH    = SETS * WPL;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
    return SET_W'((a >> OFF_W) & 32'(SETS - 1));
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
    return TAG_W'(a >> (OFF_W + LOG_SETS));
  endfunction

  function automatic logic [WI_W-1:0] wi_of(input logic [31:0] a);
    return WI_W'((a >> 2) & 32'(WPL - 1));
  endfunction

  function automatic logic [DADDR_W-1:0] daddr_of(input logic [SET_W-1:0] s,
                                                   input logic [WI_W-1:0] w);
    return DADDR_W'(((32'(s) << LOG_WPL) | 32'(w)) & 32'(DEPTH - 1));
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] size_mask(input logic [2:0] s);
    if (s == 3'd1) return 32'h0000_00FF;
    if (s == 3'd2) return 32'h0000_FFFF;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    return (l >> 1) ^ (l[0] ? LFSR_TAPS : 16'h0000);
  endfunction

  // One restoring step of the reduction modulo WAYS.
  function automatic logic [4:0] mod_step(input logic [4:0] r, input logic b);
    logic [5:0] t;
    t = {r, b};
    if (t >= 6'(WAYS)) t = t - 6'(WAYS);
    return t[4:0];
  endfunction

  state_t              state;
  q_item_t             cur;
  logic [TAG_W-1:0]    tag_mem  [WAYS][SETS];
  logic [31:0]         data_mem [WAYS][DEPTH];
  logic [TAG_W-1:0]    tag_rd   [WAYS];
  logic [31:0]         word_rd  [WAYS];
  logic [SETS-1:0][WAYS-1:0] line_valid;

  logic                miss_pending;
  logic [31:0]         miss_address;
  logic [2:0]          miss_size;
  logic [WAY_W-1:0]    miss_way;
  logic [WI_W-1:0]     refill_index;
  logic [31:0]         miss_word;
  logic [15:0]         victim_lfsr;
  logic [4:0]          vm_hi;
  logic [7:0]          vm_lo;
  logic [4:0]          vm;

  // Combinational action of the look-up cycle.
  logic                go;
  logic [SET_W-1:0]    c_set;
  logic [SET_W-1:0]    m_set;
  logic                hit_any;
  logic [WAY_W-1:0]    hit_way;
  logic [31:0]         hword;
  logic [4:0]          sh;
  logic [31:0]         lanes;
  logic [31:0]         wdat;
  logic [31:0]         fword;
  logic                fill_last;
  logic                do_miss;
  logic                do_fill;
  logic                r_emit;
  logic [2:0]          r_kind;
  logic [31:0]         r_rd;
  logic [31:0]         r_ma;
  logic [31:0]         r_md;
  logic [3:0]          r_bm;
  logic                r_hit;
  logic [31:0]         hits_next;
  logic [31:0]         acc_next;
  logic [31:0]         lat_next;
  logic                dwe;
  logic [WAY_W-1:0]    dway;
  logic [DADDR_W-1:0]  dadr;
  logic [31:0]         ddat;
  logic                twe;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign go    = (state == S_LOOK) && (!out_valid || !out_stall);
  assign c_set = set_of(cur.address);
  assign m_set = set_of(miss_address);
  assign sh    = {cur.address[1:0], 3'b000};
  assign fill_last = (refill_index == WI_W'(WPL - 1));

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && line_valid[c_set][w] && tag_rd[w] == tag_of(cur.address)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    hword = word_rd[hit_way];
    lanes = size_mask(cur.size) << sh;
    wdat  = (cur.wdata << sh) & lanes;
    fword = (refill_index == wi_of(miss_address)) ? cur.rdata : miss_word;
    r_emit = 1'b0;
    r_kind = KIND_READ;
    r_rd = '0;
    r_ma = '0;
    r_md = '0;
    r_bm = '0;
    r_hit = 1'b0;
    hits_next = hit_count;
    acc_next  = access_count;
    lat_next  = time_total;
    do_miss = 1'b0;
    do_fill = 1'b0;
    dwe  = 1'b0;
    dway = hit_way;
    dadr = daddr_of(c_set, wi_of(cur.address));
    ddat = (hword & ~lanes) | wdat;
    twe  = 1'b0;
    if (go) begin
      priority if (cur.op == OP_REFILL) begin
        if (miss_pending) begin
          do_fill = 1'b1;
          dwe  = 1'b1;
          dway = miss_way;
          dadr = daddr_of(m_set, refill_index);
          ddat = cur.rdata;
          if (fill_last) begin
            twe    = 1'b1;
            r_emit = 1'b1;
            r_kind = KIND_READ;
            r_rd   = (fword >> {miss_address[1:0], 3'b000}) & size_mask(miss_size);
          end
        end
      end else if (cur.op == OP_DROP) begin
        r_emit = 1'b0;
      end else if (miss_pending) begin
        r_emit = 1'b1;
        r_kind = KIND_BUSY;
      end else if (cur.op == OP_BAD) begin
        r_emit = 1'b1;
        r_kind = KIND_MISAL;
      end else begin
        r_emit   = 1'b1;
        acc_next = sat_add(access_count, 32'd1);
        if (hit_any) begin
          hits_next = sat_add(hit_count, 32'd1);
          lat_next  = sat_add(time_total, 32'd10);
        end else begin
          lat_next  = sat_add(time_total, 32'd110);
        end
        if (cur.op == OP_READ) begin
          if (hit_any) begin
            r_kind = KIND_READ;
            r_rd   = (hword >> sh) & size_mask(cur.size);
            r_hit  = 1'b1;
          end else begin
            do_miss = 1'b1;
            r_kind  = KIND_REQ;
            r_ma    = cur.address & ~32'(LINE_BYTES - 1);
          end
        end else begin
          r_kind = KIND_MEMW;
          r_ma   = {cur.address[31:2], 2'b00};
          r_md   = wdat;
          r_bm   = 4'((cur.size == 3'd1) ? 4'h1 : ((cur.size == 3'd2) ? 4'h3 : 4'hF))
                   << cur.address[1:0];
          r_hit  = hit_any;
          dwe    = hit_any;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_rd[w]  <= tag_mem[w][set_of(q_item.address)];
        word_rd[w] <= data_mem[w][daddr_of(set_of(q_item.address), wi_of(q_item.address))];
      end
    end
    if (dwe) begin
      data_mem[dway][dadr] <= ddat;
    end
    if (twe) begin
      tag_mem[miss_way][m_set] <= tag_of(miss_address);
    end
  end

  // Victim way: the next LFSR value reduced modulo WAYS over two stages.
  always_ff @(posedge clk) begin
    logic [15:0] n;
    logic [4:0]  r;
    n = lfsr_step(victim_lfsr);
    r = '0;
    for (int i = 15; i >= 8; i--) r = mod_step(r, n[i]);
    vm_hi <= r;
    vm_lo <= n[7:0];
    r = vm_hi;
    for (int i = 7; i >= 0; i--) r = mod_step(r, vm_lo[i]);
    vm <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      miss_pending <= 1'b0;
      miss_address <= '0;
      miss_size    <= '0;
      miss_way     <= '0;
      refill_index <= '0;
      victim_lfsr  <= LFSR_SEED;
      hit_count    <= '0;
      access_count <= '0;
      time_total   <= '0;
      line_valid   <= '0;
    end else begin
      if (go && r_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (go) begin
            state        <= S_IDLE;
            hit_count    <= hits_next;
            access_count <= acc_next;
            time_total   <= lat_next;
            if (r_emit) begin
              kind          <= r_kind;
              read_data     <= r_rd;
              mem_address   <= r_ma;
              mem_data      <= r_md;
              mem_byte_mask <= r_bm;
              hit           <= r_hit;
            end
            if (do_miss) begin
              miss_pending  <= 1'b1;
              miss_address  <= cur.address;
              miss_size     <= cur.size;
              miss_way      <= WAY_W'(vm);
              refill_index  <= '0;
              victim_lfsr   <= lfsr_step(victim_lfsr);
              line_valid[c_set][WAY_W'(vm)] <= 1'b0;
            end
            if (do_fill) begin
              refill_index <= fill_last ? '0 : refill_index + WI_W'(1);
              if (refill_index == wi_of(miss_address)) begin
                miss_word <= cur.rdata;
              end
              if (fill_last) begin
                miss_pending <= 1'b0;
                line_valid[m_set][miss_way] <= 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/set_assoc_write_through_cache.sv
// Top level of the set-associative write-through, no-write-allocate data cache.
`timescale 1ns / 1ps

// Every item (read, write or refill word) passes a front end that checks
// size and alignment and parks it in a two-entry queue, so the input side
// keeps flowing while the back end or the result port is stalled, until
// the queue is full. The back end takes one item at a time: in its idle
// state it reads the tag and data memories for every way of the set, in
// its look-up state it compares tags, updates the memories and loads the
// result register, waiting there while a stalled result is not yet taken.
// A read miss emits a block read request; the line is filled by refill
// items in ascending word order and the read data follows the last one.
// Reads and writes that arrive during a miss get a busy result. Writes
// always go to memory and update the line only on a hit. Line valid bits
// are cleared by reset; tags and data need no clearing. The victim way
// comes from a 16-bit LFSR reduced modulo the way count over two register stages.
// SETS and LINE_BYTES must be powers of two.

module set_assoc_write_through_cache import sac_pkg::*; #(
  parameter int SETS       = DEF_SETS,
  parameter int WAYS       = DEF_WAYS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic [2:0]  size_bytes,
  input  logic [31:0] write_data,
  input  logic [31:0] refill_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] read_data,
  output logic [31:0] mem_address,
  output logic [31:0] mem_data,
  output logic [3:0]  mem_byte_mask,
  output logic        hit,
  output logic [31:0] hit_count,
  output logic [31:0] access_count,
  output logic [31:0] time_total
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  sac_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .address     (address),
    .size_bytes  (size_bytes),
    .write_data  (write_data),
    .refill_data (refill_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  sac_back #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .read_data     (read_data),
    .mem_address   (mem_address),
    .mem_data      (mem_data),
    .mem_byte_mask (mem_byte_mask),
    .hit           (hit),
    .hit_count     (hit_count),
    .access_count  (access_count),
    .time_total    (time_total)
  );

endmodule

### rtl/sac_checker.sv
// Port-level checks for the cache and the bind that attaches them.
`timescale 1ns / 1ps

module sac_checker import sac_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  kind,
  input logic [31:0] read_data,
  input logic [31:0] mem_data,
  input logic [3:0]  mem_byte_mask,
  input logic        hit,
  input logic [31:0] hit_count,
  input logic [31:0] access_count
);

  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_READ |-> read_data == 32'd0)
    else $error("read data set on a non-read result");

  a_memw_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_MEMW |-> mem_byte_mask == 4'd0 && mem_data == 32'd0)
    else $error("write lanes set on a non-write result");

  a_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REQ || kind == KIND_MISAL || kind == KIND_BUSY) |-> !hit)
    else $error("hit flagged on a request, error or busy result");

  a_hits_le_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_count <= access_count)
    else $error("more hits than accesses");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind))
    else $error("stalled result changed");

endmodule

bind set_assoc_write_through_cache sac_checker u_sac_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .kind          (kind),
  .read_data     (read_data),
  .mem_data      (mem_data),
  .mem_byte_mask (mem_byte_mask),
  .hit           (hit),
  .hit_count     (hit_count),
  .access_count  (access_count)
);

### tb/set_assoc_write_through_cache_test.sv
// Self-checking testbench for the set-associative write-through cache.
`timescale 1ns / 1ps

module set_assoc_write_through_cache_test;
  import sac_pkg::*;

  localparam int SETS = DEF_SETS;
  localparam int WAYS = DEF_WAYS;
  localparam int LINE_BYTES = DEF_LINE_BYTES;
  localparam int WPL = LINE_BYTES / 4;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] read_data;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic [3:0]  mem_byte_mask;
    logic        hit;
    logic [31:0] hit_count;
    logic [31:0] access_count;
    logic [31:0] time_total;
  } cache_result_t;

  // The scoreboard carries its own copy of the cache contents and counters.
  // Each accepted item is applied to that copy; any result it causes is
  // queued and compared against the block's results in order.
  class cache_scoreboard;
    bit          valid_bits[SETS*WAYS];
    logic [31:0] tags[SETS*WAYS];
    logic [31:0] words[SETS*WAYS*WPL];
    bit          pending;
    logic [31:0] pend_addr;
    logic [2:0]  pend_size;
    int          pend_way;
    int          fill_idx;
    logic [15:0] lfsr;
    logic [31:0] hits, accesses, latency;
    cache_result_t awaited[$];
    int errors;
    int reads_hit, reads_missed, writes_hit, writes_missed, busies, misaligned;

    function new();
      foreach (valid_bits[i]) valid_bits[i] = 0;
      pending = 0; pend_addr = 0; pend_size = 0; pend_way = 0; fill_idx = 0;
      lfsr = 16'hACE1; hits = 0; accesses = 0; latency = 0; errors = 0;
    endfunction

    function logic [31:0] sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + b;
      return s[32] ? 32'hffffffff : s[31:0];
    endfunction

    function logic [31:0] mask_of(logic [2:0] sz);
      return sz == 1 ? 32'hff : (sz == 2 ? 32'hffff : 32'hffffffff);
    endfunction

    function int slot_of(logic [31:0] a, int w);
      int st;
      st = (a / LINE_BYTES) % SETS;
      return (st * WAYS + w) * WPL + (a % LINE_BYTES) / 4;
    endfunction

    function void push(logic [2:0] k, logic [31:0] rd, logic [31:0] ma,
                       logic [31:0] md, logic [3:0] bm, logic h);
      cache_result_t r;
      r.kind = k; r.read_data = rd; r.mem_address = ma; r.mem_data = md;
      r.mem_byte_mask = bm; r.hit = h; r.hit_count = hits;
      r.access_count = accesses; r.time_total = latency;
      awaited.push_back(r);
    endfunction

    function void note_item(logic [1:0] md, logic [31:0] a, logic [2:0] sz,
                            logic [31:0] wd, logic [31:0] fd);
      int st, li, w, sh;
      logic [31:0] blk, lanes, data, wrd;
      logic [3:0] bm;
      if (md == MODE_REFILL) begin
        if (!pending) return;
        st = (pend_addr / LINE_BYTES) % SETS;
        li = st * WAYS + pend_way;
        words[li * WPL + fill_idx] = fd;
        fill_idx++;
        if (fill_idx < WPL) return;
        fill_idx = 0;
        tags[li] = (pend_addr / LINE_BYTES) / SETS;
        valid_bits[li] = 1;
        pending = 0;
        wrd = words[slot_of(pend_addr, pend_way)];
        push(KIND_READ, (wrd >> (pend_addr[1:0] * 8)) & mask_of(pend_size), 0, 0, 0, 0);
        return;
      end
      if (md == 2'd3) return;
      if (pending) begin
        busies++;
        push(KIND_BUSY, 0, 0, 0, 0, 0);
        return;
      end
      if (!(sz == 1 || sz == 2 || sz == 4) || (a % sz) != 0) begin
        misaligned++;
        push(KIND_MISAL, 0, 0, 0, 0, 0);
        return;
      end
      accesses = sat(accesses, 1);
      sh = a[1:0] * 8;
      blk = a / LINE_BYTES;
      st = blk % SETS;
      w = WAYS;
      for (int i = WAYS - 1; i >= 0; i--)
        if (valid_bits[st*WAYS+i] && tags[st*WAYS+i] == blk / SETS) w = i;
      if (md == MODE_READ) begin
        if (w < WAYS) begin
          reads_hit++;
          hits = sat(hits, 1);
          latency = sat(latency, 10);
          push(KIND_READ, (words[slot_of(a, w)] >> sh) & mask_of(sz), 0, 0, 0, 1);
        end else begin
          reads_missed++;
          latency = sat(latency, 110);
          lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
          pend_way = lfsr % WAYS;
          valid_bits[st*WAYS+pend_way] = 0;
          pending = 1; pend_addr = a; pend_size = sz; fill_idx = 0;
          push(KIND_REQ, 0, blk * LINE_BYTES, 0, 0, 0);
        end
      end else begin
        lanes = mask_of(sz) << sh;
        data = (wd << sh) & lanes;
        bm = (sz == 1 ? 4'h1 : (sz == 2 ? 4'h3 : 4'hf)) << a[1:0];
        if (w < WAYS) begin
          writes_hit++;
          words[slot_of(a, w)] = (words[slot_of(a, w)] & ~lanes) | data;
          hits = sat(hits, 1);
          latency = sat(latency, 10);
        end else begin
          writes_missed++;
          latency = sat(latency, 110);
        end
        push(KIND_MEMW, 0, a & ~32'h3, data, bm, w < WAYS);
      end
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result kind=%0d", $time, got.kind);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got !== e) begin
        errors++;
        $display("%0t: mismatch expected kind=%0d rd=%h ma=%h md=%h bm=%h", $time,
                 e.kind, e.read_data, e.mem_address, e.mem_data, e.mem_byte_mask,
                 " hit=%0d hc=%0d ac=%0d tt=%0d",
                 e.hit, e.hit_count, e.access_count, e.time_total);
        $display("%0t:          actual   kind=%0d rd=%h ma=%h md=%h bm=%h", $time,
                 got.kind, got.read_data, got.mem_address, got.mem_data,
                 got.mem_byte_mask, " hit=%0d hc=%0d ac=%0d tt=%0d",
                 got.hit, got.hit_count, got.access_count, got.time_total);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [2:0]  size_bytes;
  logic [31:0] write_data, refill_data;
  logic        out_valid, out_stall;
  logic [2:0]  kind;
  logic [31:0] read_data, mem_address, mem_data;
  logic [3:0]  mem_byte_mask;
  logic        hit;
  logic [31:0] hit_count, access_count, time_total;

  cache_scoreboard board;
  int sent_items;
  int idle_cycles;

  set_assoc_write_through_cache dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: stall for a random draw before each result, check on accept.
  // A fresh draw is made after every accepted result.
  initial begin
    int hold;
    cache_result_t got;
    out_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = $urandom_range(0, 3);
      out_stall = (hold != 0);
      while (hold > 0) begin
        @(negedge clk);
        hold--;
        if (hold == 0) out_stall = 0;
      end
      do begin
        @(posedge clk);
      end while (!out_valid);
      got.kind = kind; got.read_data = read_data; got.mem_address = mem_address;
      got.mem_data = mem_data; got.mem_byte_mask = mem_byte_mask; got.hit = hit;
      got.hit_count = hit_count; got.access_count = access_count;
      got.time_total = time_total;
      board.check_result(got);
      @(negedge clk);
    end
  end

  // Watchdog: counts cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", board.awaited.size());
      $display("FAIL");
      $finish;
    end
  end

  // Presents one item after a random gap and holds it until accepted.
  task automatic send_item(logic [1:0] md, logic [31:0] a, logic [2:0] sz,
                           logic [31:0] wd, logic [31:0] fd);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; mode <= md; address <= a; size_bytes <= sz;
    write_data <= wd; refill_data <= fd;
    do @(posedge clk); while (in_stall);
    board.note_item(md, a, sz, wd, fd);
    sent_items++;
    @(negedge clk);
  endtask

  // Sends a whole refill block with random words.
  task automatic send_refill();
    for (int i = 0; i < WPL; i++)
      send_item(MODE_REFILL, $urandom, 3'($urandom_range(0, 7)), $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Addresses drawn from a small region so sets collide and lines get reused,
  // with an occasional address anywhere in the space.
  function automatic logic [31:0] pick_address(logic [2:0] sz);
    logic [31:0] a;
    if ($urandom_range(0, 9) == 0) a = $urandom;
    else a = {$urandom_range(0, 1) ? 8'hff : 8'h00, 16'h0, 8'($urandom)}
             | (32'($urandom_range(0, 3)) << 8);
    if ($urandom_range(0, 9) != 0 && sz != 0) a = a & ~32'(sz - 1);
    return a;
  endfunction

  initial begin
    int n, r;
    logic [2:0] sz;
    logic [31:0] a;
    board = new();
    sent_items = 0;
    rst = 1; in_valid = 0; mode = 0; address = 0; size_bytes = 0;
    write_data = 0; refill_data = 0;
    repeat (5) @(negedge clk);
    rst <= 0;

    // Directed: stray refill, read miss and fill, hits of every size,
    // busy during a miss, write hit and miss, bad sizes and misalignment,
    // ignored mode three, extreme addresses and data.
    send_item(MODE_REFILL, 0, 4, 0, 32'hffffffff);
    send_item(MODE_READ, 32'h0000_0004, 4, 0, 0);
    send_item(MODE_WRITE, 32'h0000_0004, 4, 32'hffffffff, 0);
    send_item(MODE_READ, 32'h0000_0004, 4, 0, 0);
    send_refill();
    send_item(MODE_READ, 32'h0000_0005, 1, 0, 0);
    send_item(MODE_READ, 32'h0000_0006, 2, 0, 0);
    send_item(MODE_WRITE, 32'h0000_0007, 1, 32'hffffffff, 0);
    send_item(MODE_WRITE, 32'h0000_0002, 2, 32'h0000a5a5, 0);
    send_item(MODE_READ, 32'h0000_0004, 4, 0, 0);
    send_item(MODE_WRITE, 32'hffff_fffc, 4, 32'h12345678, 0);
    send_item(MODE_READ, 32'h0000_0001, 2, 0, 0);
    send_item(MODE_READ, 32'h0000_0002, 4, 0, 0);
    send_item(MODE_READ, 32'h0000_0000, 3, 0, 0);
    send_item(MODE_WRITE, 32'h0000_0000, 0, 0, 0);
    send_item(MODE_READ, 32'h0000_0000, 7, 0, 0);
    send_item(2'd3, 32'hffffffff, 7, 32'hffffffff, 32'hffffffff);
    send_item(MODE_READ, 32'hffff_ffff, 1, 0, 0);
    send_refill();
    send_item(MODE_READ, 32'hffff_fffc, 4, 0, 0);

    // Hold off until the block has answered everything outstanding.
    drain();

    // Random part: mostly valid reads and writes over a small footprint;
    // every miss is followed, most of the time, by its refill block.
    for (n = 0; sent_items < 440; n++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: sz = 3'($urandom_range(0, 7));
        1, 2, 3: sz = 1;
        4, 5: sz = 2;
        default: sz = 4;
      endcase
      a = pick_address(sz);
      if (board.pending) begin
        if (r < 85) send_refill();
        else if (r < 95) send_item(r[0] ? MODE_READ : MODE_WRITE, a, sz, $urandom, 0);
        else send_item(MODE_REFILL, a, sz, $urandom, $urandom);
      end else if (r < 55) send_item(MODE_READ, a, sz, 0, $urandom);
      else if (r < 92) send_item(MODE_WRITE, a, sz, $urandom, $urandom);
      else if (r < 96) send_item(MODE_REFILL, a, sz, $urandom, $urandom);
      else send_item(2'd3, a, sz, $urandom, $urandom);
      if (n % 150 == 149) drain();
    end
    if (board.pending) send_refill();
    drain();

    $display("covered %0d read hits, %0d read misses, %0d write hits, %0d write misses,",
             board.reads_hit, board.reads_missed, board.writes_hit, board.writes_missed);
    $display("%0d busy answers and %0d rejected accesses", board.busies, board.misaligned);
    if (board.errors == 0 && board.awaited.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### filelist.f
rtl/sac_pkg.sv
rtl/sac_front.sv
rtl/sac_back.sv
rtl/set_assoc_write_through_cache.sv
rtl/sac_checker.sv
tb/set_assoc_write_through_cache_test.sv
